// File: hdl/pulse_width_measure_core_defines.svh
// ----------------------------------------------------------------------------
// Pulse width measure: assertion macros
// Shared assertion forms for the pulse width measure modules. The using
// module supplies clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_MEASURE_CORE_DEFINES_SVH
`define PULSE_WIDTH_MEASURE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pwm_pkg.sv
// ----------------------------------------------------------------------------
// Pulse width measure: package
// Shared types and codes for the pulse width measure block.
// ----------------------------------------------------------------------------
`default_nettype none

package pwm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PIN_SEL_W  = 5;
  localparam int unsigned TICK_W     = 32;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_SELECT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // Reset values of the registers.
  localparam logic [PIN_SEL_W-1:0] PIN_SELECT_RST    = '0;
  localparam logic                 ACTIVE_LEVEL_RST  = 1'b1;
  localparam logic [TICK_W-1:0]    TIMEOUT_TICKS_RST = 32'd1000000;

  // Input item kinds.
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic [PIN_SEL_W-1:0] pin_select;
    logic                 active_level;
    logic [TICK_W-1:0]    timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] pulse_width;
    logic              timed_out;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/pwm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Pulse width measure: configuration registers
// Holds pin select, polarity and timeout limit written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [pwm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pwm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output pwm_pkg::cfg_t                          cfg_o
);
  import pwm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_select    <= PIN_SELECT_RST;
      cfg_q.active_level  <= ACTIVE_LEVEL_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PIN_SELECT:    cfg_q.pin_select    <= cfg_data_i[PIN_SEL_W-1:0];
        CFG_ACTIVE_LEVEL:  cfg_q.active_level  <= cfg_data_i[0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[TICK_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/pwm_tracker.sv
// ----------------------------------------------------------------------------
// Pulse width measure: phase tracker
// Phase state and tick counter; computes the result of one item per cycle, advancing only while fire_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_width_measure_core_defines.svh"

module pwm_tracker #(
  parameter int unsigned PIN_COUNT = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic                        kind_i,
  input  wire logic [PIN_COUNT-1:0]        pin_levels_i,
  input  wire pwm_pkg::cfg_t               cfg_i,
  output pwm_pkg::result_t                 result_o
);
  import pwm_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DRAIN = 2'd1,
    PH_WAIT  = 2'd2,
    PH_COUNT = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   tick_count_q, tick_count_d;
  logic                pin_lvl;
  logic                act;
  logic [TICK_W-1:0]   base;
  logic                ends;
  logic                timeout;
  phase_e              stay_phase;
  result_t             res;

  // Pick the watched pin; out-of-range selects read as low.
  always_comb begin
    pin_lvl = 1'b0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if ({1'b0, cfg_i.pin_select} == 6'(i)) begin
        pin_lvl = pin_levels_i[i];
      end
    end
  end

  assign act = (pin_lvl == cfg_i.active_level);

  // Resolve fall-through between phases to one counter value and one compare.
  always_comb begin
    base       = tick_count_q;
    ends       = 1'b0;
    stay_phase = phase_q;
    unique case (phase_q)
      PH_DRAIN: stay_phase = act ? PH_DRAIN : PH_WAIT;
      PH_WAIT: begin
        if (act) begin
          stay_phase = PH_COUNT;
          base       = '0;
        end
      end
      PH_COUNT: ends = !act;
      PH_IDLE:  stay_phase = PH_IDLE;
      default:  stay_phase = PH_IDLE;
    endcase
  end

  assign timeout = (base >= cfg_i.timeout_ticks);

  always_comb begin
    phase_d      = phase_q;
    tick_count_d = tick_count_q;
    res          = '0;
    if (kind_i == KIND_START) begin
      phase_d      = PH_DRAIN;
      tick_count_d = '0;
    end else if (phase_q != PH_IDLE) begin
      if (ends) begin
        res.valid       = 1'b1;
        res.pulse_width = tick_count_q;
        phase_d         = PH_IDLE;
        tick_count_d    = '0;
      end else if (timeout) begin
        res.valid     = 1'b1;
        res.timed_out = 1'b1;
        phase_d       = PH_IDLE;
        tick_count_d  = '0;
      end else begin
        phase_d      = stay_phase;
        tick_count_d = base + TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      tick_count_q <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      tick_count_q <= tick_count_d;
    end
  end

  assign result_o = res;

  `PWM_ASSERT_SAME(a_idle_cnt_zero, phase_q == PH_IDLE, tick_count_q == '0,
                   "tick counter not cleared while idle")
  `PWM_ASSERT_SAME(a_res_needs_run, res.valid,
                   kind_i == KIND_SAMPLE && phase_q != PH_IDLE,
                   "result produced outside a measurement")
  `PWM_ASSERT_NEXT(a_start_arms, fire_i && kind_i == KIND_START,
                   phase_q == PH_DRAIN && tick_count_q == '0,
                   "start item did not arm the tracker")

endmodule

`default_nettype wire

// File: hdl/pulse_width_measure_core.sv
// ----------------------------------------------------------------------------
// Pulse width measure core
// Measures the width of one pulse of a chosen polarity on a selected pin.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries items: tuser is the kind (0 start, 1 sample), tdata
//   holds the level of every pin. A start beat arms a measurement; each
//   sample beat is one tick. The core first waits out a pulse already in
//   progress, waits for a new pulse, then counts active samples until the
//   pin goes idle, and sends that count on the master stream. If any phase
//   reaches timeout_ticks samples, the result is width 0 with tuser set.
//   Config channel writes pin_select (0), active_level (1), timeout_ticks (2);
//   it is always ready and other indexes are dropped.
// Timing:
//   One beat per cycle sustained while the result stream is not stalled. A
//   beat lands in the input register, is resolved by the tracker, and its
//   result is loaded into the output register, which drives tvalid, once
//   the tracker fires. The rate is set by the counter update and compare.
// Reset:
//   Pipeline empties, tracker idles with counter zero, registers take their
//   defaults (pin 0, high pulse, 1000000 ticks).
// Back-pressure:
//   While the result register waits on tready, the tracker holds; one more
//   beat is taken only if the input register is empty, then tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_width_measure_core_defines.svh"

module pulse_width_measure_core #(
  parameter int unsigned PIN_COUNT = 20,
  localparam int unsigned InDataW  = ((PIN_COUNT + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input item stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [InDataW-1:0]             s_axis_tdata_i,  // [PIN_COUNT-1:0] pin_levels
  input  wire logic                           s_axis_tuser_i,  // [0] kind
  // Result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [pwm_pkg::TICK_W-1:0]          m_axis_tdata_o,  // [31:0] pulse_width
  output logic                                m_axis_tuser_o,  // [0] timed_out
  // Configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pwm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pwm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pwm_pkg::*;

  cfg_t                  cfg;
  result_t               res;
  logic                  in_valid_q;
  logic                  in_kind_q;
  logic [PIN_COUNT-1:0]  in_levels_q;
  logic                  fire;
  logic                  s_fire;
  logic                  out_valid_q;
  logic [TICK_W-1:0]     out_width_q;
  logic                  out_timed_q;

  assign cfg_ready_o = 1'b1;

  pwm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the tracker whenever the result register can take its output.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register: valid resets, payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_kind_q   <= s_axis_tuser_i;
      in_levels_q <= s_axis_tdata_i[PIN_COUNT-1:0];
    end
  end

  pwm_tracker #(
    .PIN_COUNT (PIN_COUNT)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .kind_i       (in_kind_q),
    .pin_levels_i (in_levels_q),
    .cfg_i        (cfg),
    .result_o     (res)
  );

  // Result register: load a new result, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_width_q <= res.pulse_width;
      out_timed_q <= res.timed_out;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_width_q;
  assign m_axis_tuser_o  = out_timed_q;

  `PWM_ASSERT_SAME(a_timeout_zero, m_axis_tvalid_o && m_axis_tuser_o,
                   m_axis_tdata_o == '0, "timeout result with nonzero width")
  `PWM_ASSERT_SAME(a_stall_only_full, !s_axis_tready_o, in_valid_q,
                   "input stalled with an empty input register")
  `PWM_ASSERT_NEXT(a_result_lands, fire && res.valid, m_axis_tvalid_o,
                   "tracker result not presented")

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Pulse width measure core: self-checking testbench
// Streams start and pin-sample beats into the core, runs a beat-by-beat
// prediction of the pulse tracker beside it, and compares every result beat
// (width and timeout flag) against the oldest prediction. A short directed
// part is followed by random phases, each with its own register setting.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwm_pkg::*;

  localparam int NUM_PINS      = 20;
  localparam int IN_DATA_W     = ((NUM_PINS + 7) / 8) * 8;
  localparam int RAND_PHASES   = 11;
  localparam int PHASE_BEATS   = 95;
  localparam int SETTLE_CYCLES = 6;      // margin for the pipeline to drain
  localparam int LONG_HOLD     = 150;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;

  // Index with no register behind it; the core must drop such writes.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // Tracker phases of the measurement.
  typedef enum logic [1:0] {
    TRK_IDLE,
    TRK_DRAIN,   // waiting out a pulse already in progress
    TRK_WAIT,    // waiting for the pulse to begin
    TRK_COUNT    // counting active samples
  } trk_phase_e;

  typedef struct packed {
    logic                kind;
    logic [NUM_PINS-1:0] levels;
  } pin_beat_t;

  typedef struct packed {
    logic [TICK_W-1:0] width;
    logic              timed_out;
  } pulse_res_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [TICK_W-1:0]     m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  pulse_width_measure_core #(
    .PIN_COUNT(NUM_PINS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  pin_beat_t  beat_q[$];     // beats waiting for the driver
  pulse_res_t pulse_q[$];    // predicted results, oldest first

  int pushed       = 0;      // beats handed to the driver (generator only)
  int beats_taken  = 0;      // beats accepted by the core
  int cfg_beats    = 0;      // register writes accepted
  int cycle_cnt    = 0;
  int mismatches   = 0;
  int widths_seen  = 0;
  int timeouts_seen = 0;
  int widest       = 0;

  logic in_took  = 1'b0;     // input beat accepted at the last rising edge
  logic out_took = 1'b0;     // result beat accepted at the last rising edge

  logic snd_idle_en = 1'b1;  // sender inserts random gaps
  logic rcv_idle_en = 1'b1;  // receiver inserts random stalls
  int   hold_asks   = 0;     // requests for a long receiver hold-off

  // Predictor copy of the registers and the tracker state.
  logic [PIN_SEL_W-1:0] trk_sel   = PIN_SELECT_RST;
  logic                 trk_lvl   = ACTIVE_LEVEL_RST;
  logic [TICK_W-1:0]    trk_tmo   = TIMEOUT_TICKS_RST;
  trk_phase_e           trk_phase = TRK_IDLE;
  logic [TICK_W-1:0]    trk_ticks = '0;

  // --------------------------------------------------------------------------
  // Predictor: advance the tracker by one accepted beat
  // --------------------------------------------------------------------------
  task automatic track_beat(input pin_beat_t b);
    logic       pin;
    logic       act;
    pulse_res_t res;
    if (b.kind == KIND_START) begin
      // A start always rearms, even in the middle of a measurement.
      trk_phase = TRK_DRAIN;
      trk_ticks = '0;
      return;
    end
    if (trk_phase == TRK_IDLE) return;   // samples while idle are dropped
    // Pins past the last one read as low.
    pin = (trk_sel < NUM_PINS) ? b.levels[trk_sel] : 1'b0;
    act = (pin == trk_lvl);
    // A sample that ends one phase falls through into the next.
    if (trk_phase == TRK_DRAIN && !act) trk_phase = TRK_WAIT;
    if (trk_phase == TRK_WAIT && act) begin
      trk_phase = TRK_COUNT;
      trk_ticks = '0;
    end
    if (trk_phase == TRK_COUNT && !act) begin
      res.width     = trk_ticks;
      res.timed_out = 1'b0;
      pulse_q.push_back(res);
      trk_phase = TRK_IDLE;
      trk_ticks = '0;
    end else if (trk_ticks >= trk_tmo) begin
      // Staying in a phase with the counter at the limit gives up.
      res.width     = '0;
      res.timed_out = 1'b1;
      pulse_q.push_back(res);
      trk_phase = TRK_IDLE;
      trk_ticks = '0;
    end else begin
      trk_ticks = trk_ticks + TICK_W'(1);
    end
  endtask

  function automatic void flag_mismatch(input string what, input pulse_res_t want,
                                        input pulse_res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: expected width %0d timed_out %0b, got width %0d timed_out %0b",
               $realtime, what, want.width, want.timed_out, got.width, got.timed_out);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample all handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pulse_res_t got;
    pulse_res_t want;
    pin_beat_t  b;
    cycle_cnt <= cycle_cnt + 1;
    in_took   <= s_axis_tvalid_i && s_axis_tready_o;
    out_took  <= m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      // Check the result beat before predicting from this edge's input beat.
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.width     = m_axis_tdata_o;
        got.timed_out = m_axis_tuser_o;
        if (pulse_q.size() == 0) begin
          flag_mismatch("result with none expected", '0, got);
        end else begin
          want = pulse_q.pop_front();
          if (got.width !== want.width || got.timed_out !== want.timed_out)
            flag_mismatch("result mismatch", want, got);
        end
        if (got.timed_out === 1'b1) timeouts_seen++;
        else begin
          widths_seen++;
          if (int'(got.width) > widest) widest = int'(got.width);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        b.kind   = s_axis_tuser_i;
        b.levels = s_axis_tdata_i[NUM_PINS-1:0];
        track_beat(b);
        beats_taken <= beats_taken + 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PIN_SELECT:    trk_sel = cfg_data_i[PIN_SEL_W-1:0];
          CFG_ACTIVE_LEVEL:  trk_lvl = cfg_data_i[0];
          CFG_TIMEOUT_TICKS: trk_tmo = cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
        cfg_beats <= cfg_beats + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offer queued beats at the falling edge, with random gaps
  // --------------------------------------------------------------------------
  int snd_wait = 0;

  always @(negedge clk_i) begin
    pin_beat_t b;
    // Hold the current beat until it is taken.
    if (rst_ni && !(s_axis_tvalid_i && !in_took)) begin
      if (snd_wait > 0) begin
        snd_wait        <= snd_wait - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (beat_q.size() != 0) begin
        b = beat_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= b.kind;
        s_axis_tdata_i  <= {{(IN_DATA_W-NUM_PINS){1'b0}}, b.levels};
        snd_wait        <= snd_idle_en ? int'($urandom_range(0, 4)) : 0;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls after result beats, plus one long hold-off on request
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  int stall_left = 0;
  int hold_done  = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_done != hold_asks) begin
        hold_left = LONG_HOLD;
        hold_done = hold_asks;
      end
      if (out_took && rcv_idle_en) stall_left = $urandom_range(0, 4);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (called from the generator at falling edges)
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic kind, input logic [NUM_PINS-1:0] levels);
    pin_beat_t b;
    b.kind   = kind;
    b.levels = levels;
    beat_q.push_back(b);
    pushed++;
  endtask

  // Random pin levels with the measured pin forced active or idle.
  function automatic logic [NUM_PINS-1:0] levels_for(input logic pin_on);
    logic [NUM_PINS-1:0] v;
    v = NUM_PINS'($urandom());
    if (trk_sel < NUM_PINS) v[trk_sel] = pin_on ? trk_lvl : ~trk_lvl;
    return v;
  endfunction

  // Start, a running pulse to wait out, an idle stretch, the pulse, then idle.
  // Only the first keep beats go out, which makes broken sequences.
  task automatic send_pulse(input int lead, input int space, input int wid,
                            input int keep);
    int total;
    total = lead + space + wid + 2;
    for (int i = 0; i < total && i < keep; i++) begin
      if (i == 0)                        push_beat(KIND_START, NUM_PINS'($urandom()));
      else if (i <= lead)                push_beat(KIND_SAMPLE, levels_for(1'b1));
      else if (i <= lead + space)        push_beat(KIND_SAMPLE, levels_for(1'b0));
      else if (i <= lead + space + wid)  push_beat(KIND_SAMPLE, levels_for(1'b1));
      else                               push_beat(KIND_SAMPLE, levels_for(1'b0));
    end
  endtask

  // Wait until every beat is taken and every result has arrived, then let
  // the pipeline run dry of beats that give no result.
  task automatic wait_quiet();
    while (beats_taken != pushed || pulse_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    int n;
    n = cfg_beats;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    while (cfg_beats == n) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int draw_len(input int short_max, input int long_lo,
                                  input int long_hi);
    if ($urandom_range(0, 7) == 0) return $urandom_range(long_lo, long_hi);
    return $urandom_range(0, short_max);
  endfunction

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("cycle limit reached with %0d results outstanding", pulse_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Generator: directed part, then random phases, then wrap-up
  // --------------------------------------------------------------------------
  initial begin
    logic [PIN_SEL_W-1:0] sel;
    logic                 lvl;
    logic [TICK_W-1:0]    tmo;
    int                   base;
    int                   pick;
    int                   lead;
    int                   space;
    int                   wid;

    // Hold reset from time zero, release it at a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: pin 0, high pulse, 1000000 ticks.
    push_beat(KIND_SAMPLE, 20'hFFFFF);   // sample while idle: dropped
    push_beat(KIND_START,  20'hFFFFF);   // start levels are ignored
    push_beat(KIND_SAMPLE, 20'hFFFFF);   // pulse already running
    push_beat(KIND_SAMPLE, 20'h00000);   // now waiting for a pulse
    push_beat(KIND_SAMPLE, 20'h00001);
    push_beat(KIND_SAMPLE, 20'hFFFFF);
    push_beat(KIND_SAMPLE, 20'hFFFFE);   // pulse of two ends
    push_beat(KIND_START,  20'h00000);
    push_beat(KIND_START,  20'h00000);   // start while armed restarts
    push_beat(KIND_SAMPLE, 20'h00000);
    push_beat(KIND_SAMPLE, 20'h00001);
    push_beat(KIND_SAMPLE, 20'h00000);   // width one
    push_beat(KIND_START,  20'hFFFFF);
    push_beat(KIND_SAMPLE, 20'h00001);
    push_beat(KIND_SAMPLE, 20'h00000);
    push_beat(KIND_SAMPLE, 20'h00001);   // counting
    push_beat(KIND_START,  20'h00000);   // restart mid-pulse
    push_beat(KIND_SAMPLE, 20'h00000);
    push_beat(KIND_SAMPLE, 20'h00001);
    push_beat(KIND_SAMPLE, 20'h00000);
    wait_quiet();

    // Zero timeout on the top pin with a low pulse: first staying sample
    // gives up, both while draining and while waiting.
    write_reg(CFG_TIMEOUT_TICKS, '0);
    write_reg(CFG_PIN_SELECT, CFG_DATA_W'(NUM_PINS - 1));
    write_reg(CFG_ACTIVE_LEVEL, '0);
    push_beat(KIND_START,  20'h00000);
    push_beat(KIND_SAMPLE, 20'h80000);
    push_beat(KIND_START,  20'hFFFFF);
    push_beat(KIND_SAMPLE, 20'h7FFFF);
    wait_quiet();

    // Pin past the last one reads low and never shows a high pulse.
    write_reg(CFG_PIN_SELECT, CFG_DATA_W'(2**PIN_SEL_W - 1));
    write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(1));
    write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(2));
    write_reg(CFG_NO_REG, CFG_DATA_W'($urandom()));   // dropped
    push_beat(KIND_START,  20'hFFFFF);
    push_beat(KIND_SAMPLE, 20'hFFFFF);
    push_beat(KIND_SAMPLE, 20'hFFFFF);
    push_beat(KIND_SAMPLE, 20'hFFFFF);
    wait_quiet();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // Pick a setting; pins past the end get a short limit so that such
      // measurements finish, but the last phase always takes the largest limit.
      if ($urandom_range(0, 4) == 0) sel = PIN_SEL_W'($urandom_range(NUM_PINS, 31));
      else                            sel = PIN_SEL_W'($urandom_range(0, NUM_PINS - 1));
      lvl = 1'($urandom());
      case ($urandom_range(0, 5))
        0:       tmo = '0;
        1:       tmo = TICK_W'($urandom_range(1, 8));
        2:       tmo = TICK_W'($urandom_range(9, 40));
        3:       tmo = '1;
        4:       tmo = TIMEOUT_TICKS_RST;
        default: tmo = TICK_W'($urandom());
      endcase
      if (ph == 0) begin
        // Pressure phase: a tight limit gives a result every few beats.
        tmo = TICK_W'(1);
        sel = PIN_SEL_W'($urandom_range(0, NUM_PINS - 1));
      end
      if (sel >= NUM_PINS && tmo > 40) tmo = TICK_W'($urandom_range(0, 40));
      if (ph == RAND_PHASES - 1) tmo = '1;
      write_reg(CFG_PIN_SELECT, CFG_DATA_W'(sel));
      write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(lvl));
      write_reg(CFG_TIMEOUT_TICKS, tmo);

      // Some phases run with no idling on one side or the other.
      snd_idle_en <= (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rcv_idle_en <= ($urandom_range(0, 3) != 0);
      if (ph == 0) hold_asks <= hold_asks + 1;

      base = pushed;
      while (pushed - base < PHASE_BEATS) begin
        pick  = $urandom_range(0, 9);
        lead  = draw_len(4, 10, 40);
        space = draw_len(5, 10, 40);
        wid   = draw_len(12, 20, 60);
        if (pick < 7) begin
          send_pulse(lead, space, wid, lead + space + wid + 2);
        end else if (pick < 9) begin
          // Noise: random kinds and levels.
          repeat ($urandom_range(1, 4))
            push_beat(($urandom_range(0, 3) == 0) ? KIND_START : KIND_SAMPLE,
                      NUM_PINS'($urandom()));
        end else begin
          send_pulse(lead, space, wid, $urandom_range(1, lead + space + wid + 1));
        end
      end
      wait_quiet();
    end

    $display("%0d beats and %0d register writes; %0d widths (widest %0d) and %0d timeouts",
             beats_taken, cfg_beats, widths_seen, widest, timeouts_seen);
    $display("checked across %0d register settings", RAND_PHASES + 3);
    if (mismatches == 0 && pulse_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pulse_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
